// ===== rtl/lrtf_pkg.sv =====
// Shared constants and controller/datapath interface types for the LRTF scheduler.
package lrtf_pkg;

  localparam int unsigned MAX_JOBS = 16;
  localparam int unsigned IDX_W    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int unsigned CNT_W    = $clog2(MAX_JOBS + 1);
  localparam int unsigned ID_W     = 16;
  localparam int unsigned TIME_W   = 12;
  localparam int unsigned RES_W    = 17;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic             load_we;     // write input job into entry idx
    logic             sched_start; // clear the simulated clock
    logic             scan_en;     // compare entry idx against the current best
    logic             scan_first;  // first entry of a scan: best is empty
    logic             apply;       // run the picked job for one unit or jump idle time
    logic             emit_load;   // load the result registers from entry idx
    logic             emit_last;   // result being loaded is the final one
    logic [IDX_W-1:0] idx;         // entry address
  } ctl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic any_unfinished;          // last scan found a job with service left
  } dp_stat_t;

endpackage

// ===== rtl/longest_remaining_time_first_scheduler_top.sv =====
// Top level of the longest-remaining-time-first scheduler.
// Jobs are taken one per cycle while the block is loading; up to MAX_JOBS are held and further
// jobs of a set are dropped. The transfer carrying last_job starts scheduling, during which
// in_stall_o is high. Each simulated time unit (a run of one unit, or a jump over idle time to
// the next arrival) takes a sequential scan over the held entries, one entry per cycle, that
// picks the job with the most remaining time, followed by an apply step. Results then leave in
// load order, each held until its transfer completes, and loading resumes after the transfer of
// the result flagged last_result_o.
module longest_remaining_time_first_scheduler_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [lrtf_pkg::ID_W-1:0]    job_id_i,
  input  logic [lrtf_pkg::TIME_W-1:0]  arrival_time_i,
  input  logic [lrtf_pkg::TIME_W-1:0]  burst_time_i,
  input  logic                         last_job_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [lrtf_pkg::ID_W-1:0]    result_id_o,
  output logic [lrtf_pkg::RES_W-1:0]   completion_time_o,
  output logic [lrtf_pkg::RES_W-1:0]   turnaround_o,
  output logic [lrtf_pkg::RES_W-1:0]   waiting_o,
  output logic                         last_result_o
);
  import lrtf_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // Sequencer
  lrtf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .last_job_i  (last_job_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // Stores and arithmetic
  lrtf_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .job_id_i          (job_id_i),
    .arrival_time_i    (arrival_time_i),
    .burst_time_i      (burst_time_i),
    .result_id_o       (result_id_o),
    .completion_time_o (completion_time_o),
    .turnaround_o      (turnaround_o),
    .waiting_o         (waiting_o),
    .last_result_o     (last_result_o)
  );

endmodule

// ===== rtl/lrtf_ctrl.sv =====
// Controller state machine: load, per-time-unit scan, apply and result emission.
module lrtf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                last_job_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lrtf_pkg::ctl_cmd_t  cmd_o,
  input  lrtf_pkg::dp_stat_t  stat_i
);
  import lrtf_pkg::*;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_APPLY,
    ST_EMIT,
    ST_WAIT
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] idx_q;
  logic             out_valid_q;

  logic             in_acc;
  logic             at_last;

  assign in_stall_o  = (state_q != ST_LOAD);
  assign in_acc      = in_valid_i && (state_q == ST_LOAD);
  assign at_last     = (CNT_W'(idx_q + 1'b1) == cnt_q);
  assign out_valid_o = out_valid_q;

  // Command decode
  always_comb begin
    cmd_o             = '0;
    cmd_o.load_we     = in_acc && (cnt_q < CNT_W'(MAX_JOBS));
    cmd_o.sched_start = in_acc && last_job_i;
    cmd_o.scan_en     = (state_q == ST_SCAN);
    cmd_o.scan_first  = (idx_q == '0);
    cmd_o.apply       = (state_q == ST_APPLY);
    cmd_o.emit_load   = (state_q == ST_EMIT);
    cmd_o.emit_last   = at_last;
    cmd_o.idx         = (state_q == ST_LOAD) ? cnt_q[IDX_W-1:0] : idx_q[IDX_W-1:0];
  end

  // State, counters and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_LOAD: begin
          if (in_acc) begin
            if (cmd_o.load_we) cnt_q <= CNT_W'(cnt_q + 1'b1);
            if (last_job_i) begin
              idx_q   <= '0;
              state_q <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (at_last) state_q <= ST_APPLY;
          else         idx_q   <= CNT_W'(idx_q + 1'b1);
        end
        ST_APPLY: begin
          idx_q   <= '0;
          state_q <= stat_i.any_unfinished ? ST_SCAN : ST_EMIT;
        end
        ST_EMIT: begin
          out_valid_q <= 1'b1;
          state_q     <= ST_WAIT;
        end
        ST_WAIT: begin
          // hold the result until the transfer completes
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            if (at_last) begin
              cnt_q   <= '0;
              state_q <= ST_LOAD;
            end else begin
              idx_q   <= CNT_W'(idx_q + 1'b1);
              state_q <= ST_EMIT;
            end
          end
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

endmodule

// ===== rtl/lrtf_datapath.sv =====
// Datapath: job stores, simulated clock, best-candidate search and result registers.
module lrtf_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lrtf_pkg::ctl_cmd_t           cmd_i,
  output lrtf_pkg::dp_stat_t           stat_o,
  input  logic [lrtf_pkg::ID_W-1:0]    job_id_i,
  input  logic [lrtf_pkg::TIME_W-1:0]  arrival_time_i,
  input  logic [lrtf_pkg::TIME_W-1:0]  burst_time_i,
  output logic [lrtf_pkg::ID_W-1:0]    result_id_o,
  output logic [lrtf_pkg::RES_W-1:0]   completion_time_o,
  output logic [lrtf_pkg::RES_W-1:0]   turnaround_o,
  output logic [lrtf_pkg::RES_W-1:0]   waiting_o,
  output logic                         last_result_o
);
  import lrtf_pkg::*;

  // Job stores, read at the single controller address
  logic [ID_W-1:0]   ids_q    [MAX_JOBS];
  logic [TIME_W-1:0] arr_q    [MAX_JOBS];
  logic [TIME_W-1:0] burst_q  [MAX_JOBS];
  logic [TIME_W-1:0] rem_q    [MAX_JOBS];
  logic [RES_W-1:0]  fin_q    [MAX_JOBS];

  logic [RES_W-1:0]  t_q;
  logic              best_valid_q;
  logic [TIME_W-1:0] best_rem_q;
  logic [ID_W-1:0]   best_id_q;
  logic [IDX_W-1:0]  best_idx_q;
  logic              any_q;
  logic [TIME_W-1:0] min_arr_q;

  logic [ID_W-1:0]   id_r;
  logic [TIME_W-1:0] arr_r;
  logic [TIME_W-1:0] burst_r;
  logic [TIME_W-1:0] rem_r;
  logic [RES_W-1:0]  fin_r;
  logic              unfin;
  logic              cand;
  logic              have;
  logic              any_prev;
  logic              take;
  logic              new_min;
  logic [RES_W-1:0]  tat;

  assign id_r    = ids_q[cmd_i.idx];
  assign arr_r   = arr_q[cmd_i.idx];
  assign burst_r = burst_q[cmd_i.idx];
  assign rem_r   = rem_q[cmd_i.idx];
  assign fin_r   = fin_q[cmd_i.idx];

  // Candidate compare: most remaining time, then lowest id, then first loaded
  assign unfin    = (rem_r != '0);
  assign cand     = unfin && ({{(RES_W-TIME_W){1'b0}}, arr_r} <= t_q);
  assign have     = best_valid_q && !cmd_i.scan_first;
  assign any_prev = any_q && !cmd_i.scan_first;
  assign take     = cand && (!have || (rem_r > best_rem_q) ||
                             ((rem_r == best_rem_q) && (id_r < best_id_q)));
  assign new_min  = unfin && (!any_prev || (arr_r < min_arr_q));

  assign stat_o.any_unfinished = any_q;

  // Result arithmetic, modulo 2^RES_W
  assign tat = RES_W'(fin_r - {{(RES_W-TIME_W){1'b0}}, arr_r});

  // Stores: load writes, apply decrements the picked job
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we) begin
      ids_q[cmd_i.idx]   <= job_id_i;
      arr_q[cmd_i.idx]   <= arrival_time_i;
      burst_q[cmd_i.idx] <= burst_time_i;
      rem_q[cmd_i.idx]   <= burst_time_i;
      fin_q[cmd_i.idx]   <= {{(RES_W-TIME_W){1'b0}}, arrival_time_i};
    end
    if (cmd_i.apply && best_valid_q) begin
      rem_q[best_idx_q] <= TIME_W'(best_rem_q - 1'b1);
      if (best_rem_q == TIME_W'(1)) fin_q[best_idx_q] <= RES_W'(t_q + 1'b1);
    end
  end

  // Simulated clock and scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_q          <= '0;
      best_valid_q <= 1'b0;
      any_q        <= 1'b0;
    end else begin
      if (cmd_i.sched_start) begin
        t_q <= '0;
      end else if (cmd_i.apply) begin
        if (best_valid_q) t_q <= RES_W'(t_q + 1'b1);
        else if (any_q)   t_q <= {{(RES_W-TIME_W){1'b0}}, min_arr_q};
      end
      if (cmd_i.scan_en) begin
        best_valid_q <= take || have;
        any_q        <= unfin || any_prev;
      end
    end
  end

  // Best-candidate payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_en) begin
      if (take) begin
        best_rem_q <= rem_r;
        best_id_q  <= id_r;
        best_idx_q <= cmd_i.idx;
      end
      if (new_min) min_arr_q <= arr_r;
    end
  end

  // Result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      result_id_o       <= id_r;
      completion_time_o <= fin_r;
      turnaround_o      <= tat;
      waiting_o         <= RES_W'(tat - {{(RES_W-TIME_W){1'b0}}, burst_r});
      last_result_o     <= cmd_i.emit_last;
    end
  end

endmodule
